@@ rtl/prid_pkg.sv @@
package prid_pkg;

    // Result kinds of the decoder.
    typedef enum logic [3:0] {
        KIND_UNKNOWN = 4'd0,
        KIND_B       = 4'd1,
        KIND_BL      = 4'd2,
        KIND_BCOND   = 4'd3,
        KIND_CBZ     = 4'd4,
        KIND_CBNZ    = 4'd5,
        KIND_TBZ     = 4'd6,
        KIND_TBNZ    = 4'd7,
        KIND_ADR     = 4'd8,
        KIND_ADRP    = 4'd9,
        KIND_LDRLIT  = 4'd10
    } t_kind;

    // Literal load kinds.
    localparam logic [2:0] LIT_NONE  = 3'd0;
    localparam logic [2:0] LIT_W     = 3'd1;
    localparam logic [2:0] LIT_X     = 3'd2;
    localparam logic [2:0] LIT_SW    = 3'd3;
    localparam logic [2:0] LIT_S     = 3'd4;
    localparam logic [2:0] LIT_D     = 3'd5;
    localparam logic [2:0] LIT_Q     = 3'd6;
    localparam logic [2:0] LIT_PRFM  = 3'd7;

    // Encoding masks and match values.
    localparam logic [31:0] MASK_B     = 32'hfc000000;
    localparam logic [31:0] MATCH_B    = 32'h14000000;
    localparam logic [31:0] MATCH_BL   = 32'h94000000;
    localparam logic [31:0] MASK_BCOND = 32'hff000010;
    localparam logic [31:0] MATCH_BCOND = 32'h54000000;
    localparam logic [31:0] MASK_CMPTB = 32'h7e000000;
    localparam logic [31:0] MATCH_CB   = 32'h34000000;
    localparam logic [31:0] MATCH_TB   = 32'h36000000;
    localparam logic [31:0] MASK_ADR   = 32'h9f000000;
    localparam logic [31:0] MATCH_ADR  = 32'h10000000;
    localparam logic [31:0] MATCH_ADRP = 32'h90000000;

    // Top bytes of the literal load encodings.
    localparam logic [7:0] OPC_LDR_W    = 8'h18;
    localparam logic [7:0] OPC_LDR_X    = 8'h58;
    localparam logic [7:0] OPC_LDRSW    = 8'h98;
    localparam logic [7:0] OPC_LDR_S    = 8'h1c;
    localparam logic [7:0] OPC_LDR_D    = 8'h5c;
    localparam logic [7:0] OPC_LDR_Q    = 8'h9c;
    localparam logic [7:0] OPC_PRFM_A   = 8'hd8;
    localparam logic [7:0] OPC_PRFM_B   = 8'hdc;

    // One decoded result.
    typedef struct packed {
        t_kind       kind;
        logic        target_valid;
        logic [63:0] target_address;
        logic [3:0]  cond_code;
        logic [4:0]  reg_number;
        logic [5:0]  test_bit;
        logic        on_nonzero;
        logic        wide_reg;
        logic [2:0]  load_kind;
        logic        is_any_branch;
        logic        is_cond_branch;
    } t_result;

endpackage

@@ rtl/pc_relative_instruction_decoder.sv @@
// Channel   | Handshake            | Payload
// ----------+----------------------+-----------------------------------------------
// request   | i_valid / o_stall    | i_instr_word[31:0], i_instr_address[63:0]
// result    | o_valid / i_stall    | o_kind .. o_is_cond_branch, one per request
//
// Every request passes from acceptance to its result through an input register,
// then the decoder and the 64-bit target adder into the result register.
// One request per cycle is taken while the result side does not stall; the target adder sets the path.
// Reset (synchronous, active low) empties both register stages.
// A stall on the result side holds the result register and, once the input
// register is full as well, stalls the request side.
module pc_relative_instruction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_instr_word,
    input  logic [63:0] i_instr_address,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_kind,
    output logic        o_target_valid,
    output logic [63:0] o_target_address,
    output logic [3:0]  o_cond_code,
    output logic [4:0]  o_reg_number,
    output logic [5:0]  o_test_bit,
    output logic        o_on_nonzero,
    output logic        o_wide_reg,
    output logic [2:0]  o_load_kind,
    output logic        o_is_any_branch,
    output logic        o_is_cond_branch
);

    logic              r_in_valid;
    logic [31:0]       r_word;
    logic [63:0]       r_address;
    logic              r_out_valid;
    prid_pkg::t_result r_result;
    prid_pkg::t_result dec_result;
    logic              out_hold;
    logic              in_hold;
    logic              in_accept;

    // Stall chain: each stage holds while the one after it is full and stalled.
    assign out_hold  = r_out_valid && i_stall;
    assign in_hold   = r_in_valid && out_hold;
    assign o_stall   = in_hold;
    assign in_accept = i_valid && !in_hold;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!in_hold) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_word    <= i_instr_word;
            r_address <= i_instr_address;
        end
    end

    prid_decode u_decode (
        .i_word    (r_word),
        .i_address (r_address),
        .o_result  (dec_result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_hold) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!out_hold && r_in_valid) begin
            r_result <= dec_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_result.kind;
    assign o_target_valid   = r_result.target_valid;
    assign o_target_address = r_result.target_address;
    assign o_cond_code      = r_result.cond_code;
    assign o_reg_number     = r_result.reg_number;
    assign o_test_bit       = r_result.test_bit;
    assign o_on_nonzero     = r_result.on_nonzero;
    assign o_wide_reg       = r_result.wide_reg;
    assign o_load_kind      = r_result.load_kind;
    assign o_is_any_branch  = r_result.is_any_branch;
    assign o_is_cond_branch = r_result.is_cond_branch;

    // A held request in the input stage must reach the result stage once it frees.
    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_hold) |=> r_out_valid)
        else $error("input stage request lost");

    // A target exists exactly for recognized kinds.
    a_target_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_target_valid == (o_kind != prid_pkg::KIND_UNKNOWN)))
        else $error("target valid does not match kind");

    // Conditional branches are a subset of branches.
    a_cond_branch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_is_cond_branch) |-> o_is_any_branch)
        else $error("conditional branch not flagged as branch");

    // The request side stalls only while both stages are full.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid))
        else $error("request stalled with a free stage");

endmodule

@@ rtl/prid_decode.sv @@
module prid_decode (
    input  logic [31:0]      i_word,
    input  logic [63:0]      i_address,
    output prid_pkg::t_result o_result
);

    logic [2:0]  lit;
    logic [63:0] offset;
    logic [63:0] base;
    logic [63:0] off_imm19;
    logic [63:0] off_adr;

    // Shared immediates: imm19 scaled by four, and the 21-bit ADR immediate.
    assign off_imm19 = {{43{i_word[23]}}, i_word[23:5], 2'b00};
    assign off_adr   = {{43{i_word[23]}}, i_word[23:5], i_word[30:29]};

    // Literal load kind from the top byte.
    always_comb begin
        case (i_word[31:24])
            prid_pkg::OPC_LDR_W:  lit = prid_pkg::LIT_W;
            prid_pkg::OPC_LDR_X:  lit = prid_pkg::LIT_X;
            prid_pkg::OPC_LDRSW:  lit = prid_pkg::LIT_SW;
            prid_pkg::OPC_LDR_S:  lit = prid_pkg::LIT_S;
            prid_pkg::OPC_LDR_D:  lit = prid_pkg::LIT_D;
            prid_pkg::OPC_LDR_Q:  lit = prid_pkg::LIT_Q;
            prid_pkg::OPC_PRFM_A: lit = prid_pkg::LIT_PRFM;
            prid_pkg::OPC_PRFM_B: lit = prid_pkg::LIT_PRFM;
            default:              lit = prid_pkg::LIT_NONE;
        endcase
    end

    // Classification in priority order, with field extraction and target offset.
    always_comb begin
        o_result = '0;
        offset   = '0;
        base     = i_address;
        if ((i_word & prid_pkg::MASK_B) == prid_pkg::MATCH_B ||
            (i_word & prid_pkg::MASK_B) == prid_pkg::MATCH_BL) begin
            o_result.kind = ((i_word & prid_pkg::MASK_B) == prid_pkg::MATCH_B) ?
                            prid_pkg::KIND_B : prid_pkg::KIND_BL;
            o_result.target_valid = 1'b1;
            offset = {{36{i_word[25]}}, i_word[25:0], 2'b00};
        end else if ((i_word & prid_pkg::MASK_BCOND) == prid_pkg::MATCH_BCOND) begin
            o_result.kind         = prid_pkg::KIND_BCOND;
            o_result.cond_code    = i_word[3:0];
            o_result.target_valid = 1'b1;
            offset = off_imm19;
        end else if ((i_word & prid_pkg::MASK_CMPTB) == prid_pkg::MATCH_CB) begin
            o_result.on_nonzero   = i_word[24];
            o_result.kind = i_word[24] ? prid_pkg::KIND_CBNZ : prid_pkg::KIND_CBZ;
            o_result.wide_reg     = i_word[31];
            o_result.reg_number   = i_word[4:0];
            o_result.target_valid = 1'b1;
            offset = off_imm19;
        end else if ((i_word & prid_pkg::MASK_CMPTB) == prid_pkg::MATCH_TB) begin
            o_result.on_nonzero   = i_word[24];
            o_result.kind = i_word[24] ? prid_pkg::KIND_TBNZ : prid_pkg::KIND_TBZ;
            o_result.test_bit     = {i_word[31], i_word[23:19]};
            o_result.reg_number   = i_word[4:0];
            o_result.target_valid = 1'b1;
            offset = {{48{i_word[18]}}, i_word[18:5], 2'b00};
        end else if ((i_word & prid_pkg::MASK_ADR) == prid_pkg::MATCH_ADR) begin
            o_result.kind         = prid_pkg::KIND_ADR;
            o_result.reg_number   = i_word[4:0];
            o_result.target_valid = 1'b1;
            offset = off_adr;
        end else if ((i_word & prid_pkg::MASK_ADR) == prid_pkg::MATCH_ADRP) begin
            o_result.kind         = prid_pkg::KIND_ADRP;
            o_result.reg_number   = i_word[4:0];
            o_result.target_valid = 1'b1;
            base   = {i_address[63:12], 12'h000};
            offset = {off_adr[51:0], 12'h000};
        end else if (lit != prid_pkg::LIT_NONE) begin
            o_result.kind         = prid_pkg::KIND_LDRLIT;
            o_result.load_kind    = lit;
            o_result.reg_number   = i_word[4:0];
            o_result.target_valid = 1'b1;
            offset = off_imm19;
        end

        // The sum wraps; an unrecognized word leaves the target at zero.
        if (o_result.target_valid) begin
            o_result.target_address = base + offset;
        end

        o_result.is_any_branch = (o_result.kind >= prid_pkg::KIND_B) &&
                                 (o_result.kind <= prid_pkg::KIND_TBNZ);
        o_result.is_cond_branch = (o_result.kind >= prid_pkg::KIND_BCOND) &&
                                  (o_result.kind <= prid_pkg::KIND_TBNZ);
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    // One instruction request as offered to the decoder.
    typedef struct packed {
        logic [31:0] word;
        logic [63:0] addr;
    } t_request;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 60;
    localparam int HOLD_AT        = 150;
    localparam int RANDOM_ITEMS   = 800;
    localparam int MAX_REPORTS    = 10;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_instr_word = '0;
    logic [63:0] i_instr_address = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_kind;
    logic        o_target_valid;
    logic [63:0] o_target_address;
    logic [3:0]  o_cond_code;
    logic [4:0]  o_reg_number;
    logic [5:0]  o_test_bit;
    logic        o_on_nonzero;
    logic        o_wide_reg;
    logic [2:0]  o_load_kind;
    logic        o_is_any_branch;
    logic        o_is_cond_branch;

    t_request          pending_requests[$];
    prid_pkg::t_result expected_decodes[$];
    int                total_requests = 1;
    int                requests_taken = 0;
    int                mismatch_count = 0;
    int                quiet_cycles = 0;
    int                hold_left = 0;
    bit                hold_done = 1'b0;
    prid_pkg::t_result seen_decode;
    prid_pkg::t_result want_decode;

    pc_relative_instruction_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_instr_word     (i_instr_word),
        .i_instr_address  (i_instr_address),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_target_valid   (o_target_valid),
        .o_target_address (o_target_address),
        .o_cond_code      (o_cond_code),
        .o_reg_number     (o_reg_number),
        .o_test_bit       (o_test_bit),
        .o_on_nonzero     (o_on_nonzero),
        .o_wide_reg       (o_wide_reg),
        .o_load_kind      (o_load_kind),
        .o_is_any_branch  (o_is_any_branch),
        .o_is_cond_branch (o_is_cond_branch)
    );

    // Decode one instruction word at its address into the expected result.
    function automatic prid_pkg::t_result decode_instruction(input logic [31:0] w,
                                                             input logic [63:0] a);
        prid_pkg::t_result r;
        logic [63:0]       adr_offset;
        logic [2:0]        lit;
        r = '0;
        adr_offset = {{43{w[23]}}, w[23:5], w[30:29]};
        if ((w & prid_pkg::MASK_B) == prid_pkg::MATCH_B ||
            (w & prid_pkg::MASK_B) == prid_pkg::MATCH_BL) begin
            r.kind = ((w & prid_pkg::MASK_B) == prid_pkg::MATCH_B) ?
                     prid_pkg::KIND_B : prid_pkg::KIND_BL;
            r.target_valid = 1'b1;
            r.target_address = a + {{36{w[25]}}, w[25:0], 2'b00};
        end else if ((w & prid_pkg::MASK_BCOND) == prid_pkg::MATCH_BCOND) begin
            r.kind = prid_pkg::KIND_BCOND;
            r.cond_code = w[3:0];
            r.target_valid = 1'b1;
            r.target_address = a + {{43{w[23]}}, w[23:5], 2'b00};
        end else if ((w & prid_pkg::MASK_CMPTB) == prid_pkg::MATCH_CB) begin
            r.kind = w[24] ? prid_pkg::KIND_CBNZ : prid_pkg::KIND_CBZ;
            r.on_nonzero = w[24];
            r.wide_reg = w[31];
            r.reg_number = w[4:0];
            r.target_valid = 1'b1;
            r.target_address = a + {{43{w[23]}}, w[23:5], 2'b00};
        end else if ((w & prid_pkg::MASK_CMPTB) == prid_pkg::MATCH_TB) begin
            r.kind = w[24] ? prid_pkg::KIND_TBNZ : prid_pkg::KIND_TBZ;
            r.on_nonzero = w[24];
            r.test_bit = {w[31], w[23:19]};
            r.reg_number = w[4:0];
            r.target_valid = 1'b1;
            r.target_address = a + {{48{w[18]}}, w[18:5], 2'b00};
        end else if ((w & prid_pkg::MASK_ADR) == prid_pkg::MATCH_ADR) begin
            r.kind = prid_pkg::KIND_ADR;
            r.reg_number = w[4:0];
            r.target_valid = 1'b1;
            r.target_address = a + adr_offset;
        end else if ((w & prid_pkg::MASK_ADR) == prid_pkg::MATCH_ADRP) begin
            r.kind = prid_pkg::KIND_ADRP;
            r.reg_number = w[4:0];
            r.target_valid = 1'b1;
            r.target_address = (a & ~64'hfff) + (adr_offset << 12);
        end else begin
            case (w[31:24])
                prid_pkg::OPC_LDR_W:  lit = prid_pkg::LIT_W;
                prid_pkg::OPC_LDR_X:  lit = prid_pkg::LIT_X;
                prid_pkg::OPC_LDRSW:  lit = prid_pkg::LIT_SW;
                prid_pkg::OPC_LDR_S:  lit = prid_pkg::LIT_S;
                prid_pkg::OPC_LDR_D:  lit = prid_pkg::LIT_D;
                prid_pkg::OPC_LDR_Q:  lit = prid_pkg::LIT_Q;
                prid_pkg::OPC_PRFM_A: lit = prid_pkg::LIT_PRFM;
                prid_pkg::OPC_PRFM_B: lit = prid_pkg::LIT_PRFM;
                default:              lit = prid_pkg::LIT_NONE;
            endcase
            if (lit != prid_pkg::LIT_NONE) begin
                r.kind = prid_pkg::KIND_LDRLIT;
                r.load_kind = lit;
                r.reg_number = w[4:0];
                r.target_valid = 1'b1;
                r.target_address = a + {{43{w[23]}}, w[23:5], 2'b00};
            end
        end
        r.is_any_branch = (r.kind >= prid_pkg::KIND_B) && (r.kind <= prid_pkg::KIND_TBNZ);
        r.is_cond_branch = (r.kind >= prid_pkg::KIND_BCOND) &&
                           (r.kind <= prid_pkg::KIND_TBNZ);
        return r;
    endfunction

    // Literal load top bytes, picked at random.
    function automatic logic [7:0] random_literal_opcode();
        case ($urandom_range(7))
            0: return prid_pkg::OPC_LDR_W;
            1: return prid_pkg::OPC_LDR_X;
            2: return prid_pkg::OPC_LDRSW;
            3: return prid_pkg::OPC_LDR_S;
            4: return prid_pkg::OPC_LDR_D;
            5: return prid_pkg::OPC_LDR_Q;
            6: return prid_pkg::OPC_PRFM_A;
            default: return prid_pkg::OPC_PRFM_B;
        endcase
    endfunction

    // Mostly well-formed encodings with random fields, some noise and near misses.
    function automatic logic [31:0] random_word();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(12))
            0: return (r & ~prid_pkg::MASK_B) | prid_pkg::MATCH_B;
            1: return (r & ~prid_pkg::MASK_B) | prid_pkg::MATCH_BL;
            2: return (r & ~prid_pkg::MASK_BCOND) | prid_pkg::MATCH_BCOND;
            3: return (r & ~prid_pkg::MASK_CMPTB) | prid_pkg::MATCH_CB;
            4: return (r & ~prid_pkg::MASK_CMPTB) | prid_pkg::MATCH_TB;
            5: return (r & ~prid_pkg::MASK_ADR) | prid_pkg::MATCH_ADR;
            6: return (r & ~prid_pkg::MASK_ADR) | prid_pkg::MATCH_ADRP;
            7, 8: return {random_literal_opcode(), r[23:0]};
            9: return ((r & ~prid_pkg::MASK_CMPTB) | prid_pkg::MATCH_CB) ^
                      (32'h1 << $urandom_range(31, 24));
            10: return ((r & ~prid_pkg::MASK_BCOND) | prid_pkg::MATCH_BCOND) ^
                       (32'h1 << $urandom_range(31, 24));
            default: return r;
        endcase
    endfunction

    // Addresses near both ends of the range make the target sum wrap.
    function automatic logic [63:0] random_address();
        case ($urandom_range(5))
            0: return {32'hffffffff, 32'($urandom)};
            1: return {32'h0, 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    task automatic queue_request(input logic [31:0] w, input logic [63:0] a);
        t_request q;
        q.word = w;
        q.addr = a;
        pending_requests.push_back(q);
    endtask

    task automatic report_mismatch(input prid_pkg::t_result want,
                                   input prid_pkg::t_result seen);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch: kind %0d/%0d tv %0b/%0b tgt %h/%h cond %0d/%0d",
                     want.kind, seen.kind, want.target_valid, seen.target_valid,
                     want.target_address, seen.target_address,
                     want.cond_code, seen.cond_code);
            $display("  reg %0d/%0d bit %0d/%0d nz %0b/%0b wide %0b/%0b lit %0d/%0d",
                     want.reg_number, seen.reg_number, want.test_bit, seen.test_bit,
                     want.on_nonzero, seen.on_nonzero, want.wide_reg, seen.wide_reg,
                     want.load_kind, seen.load_kind);
            $display("  branch %0b/%0b cond_branch %0b/%0b (expected/actual)",
                     want.is_any_branch, seen.is_any_branch,
                     want.is_cond_branch, seen.is_cond_branch);
        end
    endtask

    // The run is split in thirds by accepted requests for the idling pattern.
    function automatic int current_phase();
        int p;
        p = (requests_taken * 3) / total_requests;
        return (p > 2) ? 2 : p;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Request driver: holds a stalled request, otherwise offers the next one or idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_decodes.push_back(decode_instruction(i_instr_word, i_instr_address));
                requests_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_requests.size() > 0 && $urandom_range(99) >=
                        ((current_phase() == 0) ? 19 : (current_phase() == 1) ? 78 : 0)) begin
                    i_valid <= 1'b1;
                    i_instr_word <= pending_requests[0].word;
                    i_instr_address <= pending_requests[0].addr;
                    pending_requests.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and receiver stall, with one long hold-off to back up the pipe.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                seen_decode.kind = prid_pkg::t_kind'(o_kind);
                seen_decode.target_valid = o_target_valid;
                seen_decode.target_address = o_target_address;
                seen_decode.cond_code = o_cond_code;
                seen_decode.reg_number = o_reg_number;
                seen_decode.test_bit = o_test_bit;
                seen_decode.on_nonzero = o_on_nonzero;
                seen_decode.wide_reg = o_wide_reg;
                seen_decode.load_kind = o_load_kind;
                seen_decode.is_any_branch = o_is_any_branch;
                seen_decode.is_cond_branch = o_is_cond_branch;
                if (expected_decodes.size() == 0) begin
                    $display("unexpected result with nothing outstanding");
                    report_mismatch('0, seen_decode);
                end else begin
                    want_decode = expected_decodes.pop_front();
                    if (seen_decode !== want_decode) begin
                        report_mismatch(want_decode, seen_decode);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else if (!hold_done && requests_taken >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) <
                            ((current_phase() == 0) ? 78 : (current_phase() == 1) ? 19 : 0));
            end
        end
    end

    // Watchdog on cycles where neither channel moves.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Directed requests: offset extremes, each kind, and near misses.
        queue_request(prid_pkg::MATCH_B | 32'h01ffffff, 64'hffffffff_fffffff0);
        queue_request(prid_pkg::MATCH_B | 32'h02000000, 64'h0);
        queue_request(prid_pkg::MATCH_BL | 32'h03ffffff, 64'h00000000_00001000);
        queue_request(prid_pkg::MATCH_BCOND | 32'h00000000, 64'hffffffff_ffffffff);
        queue_request(prid_pkg::MATCH_BCOND | 32'h00ffffef, 64'h12345678_9abcdef0);
        // B.cond with bit 4 set is not a conditional branch.
        queue_request(prid_pkg::MATCH_BCOND | 32'h00000010, 64'h00000000_00400000);
        queue_request(prid_pkg::MATCH_CB | 32'h80800000, 64'h0);
        queue_request(prid_pkg::MATCH_CB | 32'h017fffff, 64'hffffffff_fffffffc);
        queue_request(prid_pkg::MATCH_TB | 32'h80f8001f, 64'h80000000_00000000);
        queue_request(prid_pkg::MATCH_TB | 32'h0107ffe3, 64'h7fffffff_ffffffff);
        queue_request(prid_pkg::MATCH_ADR | 32'h607fffff, 64'hffffffff_ffffff00);
        queue_request(prid_pkg::MATCH_ADR | 32'h00800005, 64'h0);
        queue_request(prid_pkg::MATCH_ADRP | 32'h607fffe1, 64'hffffffff_fffff123);
        queue_request(prid_pkg::MATCH_ADRP | 32'h00800000, 64'h00000000_00000fff);
        queue_request({prid_pkg::OPC_LDR_W, 24'hffffff}, 64'hffffffff_fffffff8);
        queue_request({prid_pkg::OPC_LDR_X, 24'h800000}, 64'h0);
        queue_request({prid_pkg::OPC_LDRSW, 24'h7fffe0}, 64'hdeadbeef_00000000);
        queue_request({prid_pkg::OPC_LDR_S, 24'h00001f}, 64'h1);
        queue_request({prid_pkg::OPC_LDR_D, 24'h123456}, 64'h00000000_fffff000);
        queue_request({prid_pkg::OPC_LDR_Q, 24'hfedcba}, 64'hffffffff_00000000);
        // Both prefetch top bytes decode to the same literal kind.
        queue_request({prid_pkg::OPC_PRFM_A, 24'h000000}, 64'h55555555_aaaaaaaa);
        queue_request({prid_pkg::OPC_PRFM_B, 24'hffffff}, 64'haaaaaaaa_55555555);
        queue_request(32'h00000000, 64'hffffffff_ffffffff);
        queue_request(32'hffffffff, 64'h0);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            queue_request(random_word(), random_address());
        end
        total_requests = pending_requests.size();

        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain, then leave time for any stray result to show up.
        while (pending_requests.size() > 0 || i_valid || expected_decodes.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/prid_pkg.sv
rtl/prid_decode.sv
rtl/pc_relative_instruction_decoder.sv
verif/tb_top.sv
